// ===== rtl/core/mee_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Monomial exponent enumerator package
// Shared widths, register indexes and the control types of the cell row.
// ----------------------------------------------------------------------------
package mee_pkg;

    localparam int NUM_CELLS = 8;
    localparam int EXP_W     = 8;
    localparam int SUM_W     = EXP_W + $clog2(NUM_CELLS);
    localparam int VARS_W    = 4;
    localparam int CFG_IDX_W = 2;

    typedef logic [EXP_W-1:0]  t_exp;
    typedef logic [SUM_W-1:0]  t_sum;
    typedef logic [VARS_W-1:0] t_vars;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEGREE   = 2'd0,
        CFG_NUM_VARS = 2'd1,
        CFG_HOMOG    = 2'd2
    } t_cfg_idx;

    // Broadcast control for every cell of the row.
    typedef struct packed {
        logic load;
        logic first;
        t_exp degree;
    } t_cell_ctrl;

    // Role of one cell under the current configuration.
    typedef struct packed {
        logic free;
        logic tail;
    } t_cell_role;

endpackage

`default_nettype wire

// ===== rtl/core/mee_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Monomial exponent enumerator cell
// Holds one exponent, extends the prefix sum and works out its own successor.
// ----------------------------------------------------------------------------
module mee_cell (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire mee_pkg::t_cell_ctrl i_ctrl,
    input  wire mee_pkg::t_cell_role i_role,
    input  wire mee_pkg::t_sum       i_sum,
    output mee_pkg::t_sum            o_sum,
    input  wire                      i_next_lt,
    output logic                     o_lt,
    input  wire                      i_bump,
    output logic                     o_bump,
    input  wire mee_pkg::t_exp       i_new_sum,
    output mee_pkg::t_exp            o_new_sum,
    output mee_pkg::t_exp            o_exp,
    output mee_pkg::t_exp            o_next_exp
);

    mee_pkg::t_exp r_exp;
    mee_pkg::t_exp n_exp;
    logic          is_pivot;

    assign o_sum = i_role.free ? (i_sum + mee_pkg::SUM_W'(r_exp)) : i_sum;
    assign o_lt  = i_role.free &&
                   (o_sum < mee_pkg::SUM_W'(i_ctrl.degree));

    // The pivot is the rightmost free cell whose prefix sum stays below the degree.
    assign is_pivot = o_lt && !i_next_lt;
    assign o_bump   = i_bump || is_pivot;

    // The prefix here is below the degree, so one more still fits in EXP_W bits.
    assign o_new_sum = is_pivot ? (o_sum[mee_pkg::EXP_W-1:0] + 1'b1) : i_new_sum;

    always_comb begin
        if (i_role.tail) begin
            n_exp = i_ctrl.first ? i_ctrl.degree : (i_ctrl.degree - i_new_sum);
        end else if (i_role.free) begin
            if (i_ctrl.first) begin
                n_exp = '0;
            end else if (is_pivot) begin
                n_exp = r_exp + 1'b1;
            end else if (i_bump) begin
                n_exp = '0;
            end else begin
                n_exp = r_exp;
            end
        end else begin
            n_exp = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp <= '0;
        end else if (i_ctrl.load) begin
            r_exp <= n_exp;
        end
    end

    assign o_exp      = r_exp;
    assign o_next_exp = n_exp;

endmodule

`default_nettype wire

// ===== rtl/core/monomial_exponent_enumerator_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Monomial exponent enumerator core
// Produces exponent vectors in ascending lexicographic order, one per item.
// ----------------------------------------------------------------------------
// Each accepted input item yields exactly one result item. With i_restart
// high (or before the first accepted item) the first vector is produced; otherwise the
// successor of the held vector. After the final vector (o_is_final high) the
// following items report o_exhausted with zero exponents until a restart.
// The configuration channel (i_cfg_valid/o_cfg_ready) is always ready and
// should only be written while no item is in flight.
// A row of eight cells forms the prefix sums and finds the pivot position in
// one pass, so the successor is computed in the cycle the item is accepted.
// o_out_valid rises in the cycle after acceptance, and an item can be
// accepted in every unstalled cycle. A result waiting in the output register
// under i_out_stall holds its payload and stalls the input for as long as the
// stall lasts; a result taken in the same cycle makes room for the next item.
// Reset clears the held vector, the output valid flag and the configuration
// (degree 0, one variable, normal mode).
// ----------------------------------------------------------------------------
module monomial_exponent_enumerator_core (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    output logic                          o_in_stall,
    input  wire                           i_restart,
    output logic                          o_out_valid,
    input  wire                           i_out_stall,
    output mee_pkg::t_exp                 o_exp0,
    output mee_pkg::t_exp                 o_exp1,
    output mee_pkg::t_exp                 o_exp2,
    output mee_pkg::t_exp                 o_exp3,
    output mee_pkg::t_exp                 o_exp4,
    output mee_pkg::t_exp                 o_exp5,
    output mee_pkg::t_exp                 o_exp6,
    output mee_pkg::t_exp                 o_exp7,
    output logic                          o_is_final,
    output logic                          o_exhausted,
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire [mee_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire mee_pkg::t_exp            i_cfg_data
);

    localparam int N = mee_pkg::NUM_CELLS;

    mee_pkg::t_exp  r_degree;
    mee_pkg::t_vars r_num_vars;
    logic           r_homog;
    logic           r_started;
    logic           r_done;
    logic           r_out_valid;
    mee_pkg::t_exp  r_out_exp [N];
    logic           r_out_final;
    logic           r_out_exh;

    mee_pkg::t_vars eff_vars;
    mee_pkg::t_vars free_cnt;
    logic           accept;
    logic           first;
    logic           exhaust;
    logic           next_final;
    mee_pkg::t_cell_ctrl ctrl;
    mee_pkg::t_cell_role role [N];

    mee_pkg::t_sum  sum_chain  [N+1];
    logic           bump_chain [N+1];
    mee_pkg::t_exp  nsum_chain [N+1];
    logic           lt         [N];
    logic           next_lt    [N];
    mee_pkg::t_exp  cur_exp    [N];
    mee_pkg::t_exp  next_exp   [N];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree   <= '0;
            r_num_vars <= mee_pkg::t_vars'(1);
            r_homog    <= 1'b0;
        end else if (i_cfg_valid) begin
            case (mee_pkg::t_cfg_idx'(i_cfg_index))
                mee_pkg::CFG_DEGREE:   r_degree   <= i_cfg_data;
                mee_pkg::CFG_NUM_VARS: r_num_vars <= i_cfg_data[mee_pkg::VARS_W-1:0];
                mee_pkg::CFG_HOMOG:    r_homog    <= i_cfg_data[0];
                default:               r_homog    <= r_homog;
            endcase
        end
    end

    always_comb begin
        if (r_num_vars == '0) begin
            eff_vars = mee_pkg::t_vars'(1);
        end else if (r_num_vars > mee_pkg::t_vars'(N)) begin
            eff_vars = mee_pkg::t_vars'(N);
        end else begin
            eff_vars = r_num_vars;
        end
    end

    assign free_cnt = eff_vars - mee_pkg::t_vars'(r_homog);

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    // With no free position the single vector is already the last one.
    assign first   = i_restart || !r_started;
    assign exhaust = !first &&
                     (r_done || (free_cnt == '0) || (cur_exp[0] >= r_degree));

    assign ctrl.load   = accept && !exhaust;
    assign ctrl.first  = first;
    assign ctrl.degree = r_degree;

    assign sum_chain[0]  = '0;
    assign bump_chain[0] = 1'b0;
    assign nsum_chain[0] = '0;

    for (genvar g = 0; g < N; g++) begin : g_cell
        assign role[g].free = (mee_pkg::t_vars'(g) < free_cnt);
        assign role[g].tail = r_homog && (mee_pkg::t_vars'(g) == eff_vars - 1'b1);

        if (g == N - 1) begin : g_end
            assign next_lt[g] = 1'b0;
        end else begin : g_mid
            assign next_lt[g] = lt[g+1];
        end

        mee_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (ctrl),
            .i_role     (role[g]),
            .i_sum      (sum_chain[g]),
            .o_sum      (sum_chain[g+1]),
            .i_next_lt  (next_lt[g]),
            .o_lt       (lt[g]),
            .i_bump     (bump_chain[g]),
            .o_bump     (bump_chain[g+1]),
            .i_new_sum  (nsum_chain[g]),
            .o_new_sum  (nsum_chain[g+1]),
            .o_exp      (cur_exp[g]),
            .o_next_exp (next_exp[g])
        );
    end

    assign next_final = (free_cnt == '0) || (next_exp[0] >= r_degree);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started   <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_started   <= 1'b1;
                r_done      <= exhaust;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int k = 0; k < N; k++) begin
                r_out_exp[k] <= exhaust ? '0 : next_exp[k];
            end
            r_out_final <= !exhaust && next_final;
            r_out_exh   <= exhaust;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_exp0      = r_out_exp[0];
    assign o_exp1      = r_out_exp[1];
    assign o_exp2      = r_out_exp[2];
    assign o_exp3      = r_out_exp[3];
    assign o_exp4      = r_out_exp[4];
    assign o_exp5      = r_out_exp[5];
    assign o_exp6      = r_out_exp[6];
    assign o_exp7      = r_out_exp[7];
    assign o_is_final  = r_out_final;
    assign o_exhausted = r_out_exh;

endmodule

`default_nettype wire
